// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the IPv6 text parser modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ipv6p_pkg.sv =====
// Package for the IPv6 text address parser: word types, controller types,
// character constants and the hex digit decoder. Depends on nothing.
`default_nettype none

package ipv6p_pkg;

  localparam int BYTE_COUNT = 16;
  localparam int POS_W      = 5;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  localparam logic [11:0] OCTET_MAX = 12'd255;

  // One input word: a character, or the end marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_req;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        valid_res;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SHIFT,
    ST_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step_char;
    logic finish;
    logic shift;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_pending;
    logic shift_last;
  } dp_status_t;

  // Returns {is_hex, value} for a character.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, 4'(c - CHAR_0)};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv6p_dp.sv =====
// Datapath of the IPv6 text parser: parse registers, address bytes, end
// checks, gap expansion and the result register. Uses ipv6p_pkg.
`default_nettype none
`include "assert_macros.svh"

module ipv6p_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           ch,
  input  wire ipv6p_pkg::dp_cmd_t   cmd,
  output ipv6p_pkg::dp_status_t     status,
  output ipv6p_pkg::out_word_t      res_word
);

  logic [7:0]                    addr_bytes [ipv6p_pkg::BYTE_COUNT];
  logic [ipv6p_pkg::POS_W-1:0]   write_pos, write_pos_next;
  logic [ipv6p_pkg::POS_W-1:0]   gap_pos, gap_pos_next;
  logic                          gap_seen, gap_seen_next;
  logic [15:0]                   group_value, group_value_next;
  logic [2:0]                    group_digits, group_digits_next;
  logic [8:0]                    token_decimal, token_decimal_next;
  logic                          token_not_octet, token_not_octet_next;
  logic                          dotted_mode, dotted_mode_next;
  logic [2:0]                    octet_count, octet_count_next;
  logic [7:0]                    octet_value, octet_value_next;
  logic                          octet_has_digit, octet_has_digit_next;
  logic                          at_start, at_start_next;
  logic                          need_second_colon, need_second_colon_next;
  logic                          colon_after_group, colon_after_group_next;
  logic                          failed, failed_next;
  logic                          fin_ok, fin_ok_next;
  logic [ipv6p_pkg::POS_W-1:0]   shift_cnt, shift_cnt_next;

  // Two byte write ports shared by character steps and the end step.
  logic       wr_a_en, wr_b_en;
  logic [3:0] wr_a_idx, wr_b_idx;
  logic [7:0] wr_a_data, wr_b_data;

  logic                        go;
  logic [4:0]                  hex;
  logic                        is_dig;
  logic [3:0]                  dig;
  logic [11:0]                 oct_nw;
  logic [12:0]                 tok_nw;
  logic [2:0]                  oc_eff;
  logic [ipv6p_pkg::POS_W-1:0] fin_wp;
  logic                        fin_ok_c;

  assign hex    = ipv6p_pkg::hex_decode(ch);
  assign is_dig = (ch >= ipv6p_pkg::CHAR_0) && (ch <= ipv6p_pkg::CHAR_9);
  assign dig    = 4'(ch - ipv6p_pkg::CHAR_0);
  assign oct_nw = {4'b0, octet_value} * 12'd10 + {8'b0, dig};
  assign tok_nw = {4'b0, token_decimal} * 13'd10 + {9'b0, hex[3:0]};
  assign oc_eff = octet_has_digit ? octet_count : 3'(octet_count + 3'd1);

  // Per-character parse step and the end-of-text checks.
  always_comb begin
    write_pos_next         = write_pos;
    gap_pos_next           = gap_pos;
    gap_seen_next          = gap_seen;
    group_value_next       = group_value;
    group_digits_next      = group_digits;
    token_decimal_next     = token_decimal;
    token_not_octet_next   = token_not_octet;
    dotted_mode_next       = dotted_mode;
    octet_count_next       = octet_count;
    octet_value_next       = octet_value;
    octet_has_digit_next   = octet_has_digit;
    at_start_next          = at_start;
    need_second_colon_next = need_second_colon;
    colon_after_group_next = colon_after_group;
    failed_next            = failed;
    wr_a_en   = 1'b0;
    wr_a_idx  = write_pos[3:0];
    wr_a_data = group_value[15:8];
    wr_b_en   = 1'b0;
    wr_b_idx  = 4'(write_pos[3:0] + 4'd1);
    wr_b_data = group_value[7:0];
    go        = 1'b0;
    fin_wp    = write_pos;
    fin_ok_c  = 1'b0;

    if (cmd.step_char && !failed) begin
      go = 1'b1;
      // A leading colon must be followed by a second one.
      if (at_start) begin
        at_start_next = 1'b0;
        if (ch == ipv6p_pkg::CHAR_COLON) begin
          need_second_colon_next = 1'b1;
          go = 1'b0;
        end
      end
      if (go && need_second_colon) begin
        need_second_colon_next = 1'b0;
        if (ch != ipv6p_pkg::CHAR_COLON) begin
          failed_next = 1'b1;
          go = 1'b0;
        end
      end
      if (go && dotted_mode) begin
        // Decimal octets of the trailing IPv4 quad.
        if (is_dig) begin
          if (octet_has_digit && octet_value == 8'd0) begin
            failed_next = 1'b1;
          end else if (oct_nw > ipv6p_pkg::OCTET_MAX) begin
            failed_next = 1'b1;
          end else begin
            octet_value_next = oct_nw[7:0];
            if (!octet_has_digit && octet_count >= 3'd4) begin
              failed_next = 1'b1;
            end else begin
              octet_count_next     = oc_eff;
              octet_has_digit_next = 1'b1;
              wr_a_en   = 1'b1;
              wr_a_idx  = 4'(write_pos[3:0] + {1'b0, oc_eff} - 4'd1);
              wr_a_data = oct_nw[7:0];
            end
          end
        end else if (ch == ipv6p_pkg::CHAR_DOT && octet_has_digit) begin
          if (octet_count >= 3'd4) begin
            failed_next = 1'b1;
          end else begin
            octet_value_next     = 8'd0;
            octet_has_digit_next = 1'b0;
          end
        end else begin
          failed_next = 1'b1;
        end
      end else if (go) begin
        if (hex[4]) begin
          // Hex digit; also tracked as a possible first decimal octet.
          colon_after_group_next = 1'b0;
          if (group_digits >= 3'd4) begin
            failed_next = 1'b1;
          end else begin
            group_value_next = {group_value[11:0], hex[3:0]};
            if (hex[3:0] > 4'd9) begin
              token_not_octet_next = 1'b1;
            end else if (group_digits != 3'd0 && token_decimal == 9'd0) begin
              token_not_octet_next = 1'b1;
            end else if (!token_not_octet) begin
              if (tok_nw > 13'(ipv6p_pkg::OCTET_MAX)) begin
                token_not_octet_next = 1'b1;
              end else begin
                token_decimal_next = tok_nw[8:0];
              end
            end
            group_digits_next = 3'(group_digits + 3'd1);
          end
        end else if (ch == ipv6p_pkg::CHAR_COLON) begin
          if (group_digits == 3'd0) begin
            // Empty group: this is the gap.
            if (gap_seen) begin
              failed_next = 1'b1;
            end else begin
              gap_seen_next          = 1'b1;
              gap_pos_next           = write_pos;
              colon_after_group_next = 1'b0;
            end
          end else if (write_pos > 5'd14) begin
            failed_next = 1'b1;
          end else begin
            wr_a_en = 1'b1;
            wr_b_en = 1'b1;
            write_pos_next         = 5'(write_pos + 5'd2);
            group_value_next       = '0;
            group_digits_next      = '0;
            token_decimal_next     = '0;
            token_not_octet_next   = 1'b0;
            colon_after_group_next = 1'b1;
          end
        end else if (ch == ipv6p_pkg::CHAR_DOT) begin
          // The group just read is the first octet of a dotted quad.
          colon_after_group_next = 1'b0;
          if (write_pos > 5'd12 || group_digits == 3'd0 || token_not_octet) begin
            failed_next = 1'b1;
          end else begin
            wr_a_en   = 1'b1;
            wr_a_data = token_decimal[7:0];
            dotted_mode_next     = 1'b1;
            octet_count_next     = 3'd1;
            octet_value_next     = 8'd0;
            octet_has_digit_next = 1'b0;
            group_value_next     = '0;
            group_digits_next    = '0;
            token_decimal_next   = '0;
            token_not_octet_next = 1'b0;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    // End of text: flush the last group and check the length.
    fin_ok_c = !failed && !need_second_colon;
    if (dotted_mode) begin
      if (octet_count != 3'd4) begin
        fin_ok_c = 1'b0;
      end
      fin_wp = 5'(write_pos + 5'd4);
    end else begin
      if (colon_after_group) begin
        fin_ok_c = 1'b0;
      end
      if (group_digits != 3'd0) begin
        if (write_pos > 5'd14) begin
          fin_ok_c = 1'b0;
        end else begin
          fin_wp = 5'(write_pos + 5'd2);
          if (cmd.finish) begin
            wr_a_en = 1'b1;
            wr_b_en = 1'b1;
          end
        end
      end
    end
    shift_cnt_next = shift_cnt;
    if (cmd.finish) begin
      shift_cnt_next = '0;
    end
    if (gap_seen) begin
      if (fin_wp >= 5'd16 || gap_pos > fin_wp) begin
        fin_ok_c = 1'b0;
      end else begin
        if (cmd.finish && fin_ok_c) begin
          shift_cnt_next = 5'(5'd16 - fin_wp);
        end
        fin_wp = 5'd16;
      end
    end
    if (fin_wp != 5'd16) begin
      fin_ok_c = 1'b0;
    end
    if (cmd.shift) begin
      shift_cnt_next = 5'(shift_cnt - 5'd1);
    end
  end

  assign fin_ok_next = cmd.finish ? fin_ok_c : fin_ok;

  // Control and parse registers; cleared on reset and after each result.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      write_pos         <= '0;
      gap_pos           <= '0;
      gap_seen          <= 1'b0;
      group_value       <= '0;
      group_digits      <= '0;
      token_decimal     <= '0;
      token_not_octet   <= 1'b0;
      dotted_mode       <= 1'b0;
      octet_count       <= '0;
      octet_value       <= '0;
      octet_has_digit   <= 1'b0;
      at_start          <= 1'b1;
      need_second_colon <= 1'b0;
      colon_after_group <= 1'b0;
      failed            <= 1'b0;
      fin_ok            <= 1'b0;
      shift_cnt         <= '0;
    end else begin
      write_pos         <= write_pos_next;
      gap_pos           <= gap_pos_next;
      gap_seen          <= gap_seen_next;
      group_value       <= group_value_next;
      group_digits      <= group_digits_next;
      token_decimal     <= token_decimal_next;
      token_not_octet   <= token_not_octet_next;
      dotted_mode       <= dotted_mode_next;
      octet_count       <= octet_count_next;
      octet_value       <= octet_value_next;
      octet_has_digit   <= octet_has_digit_next;
      at_start          <= at_start_next;
      need_second_colon <= need_second_colon_next;
      colon_after_group <= colon_after_group_next;
      failed            <= failed_next;
      fin_ok            <= fin_ok_next;
      shift_cnt         <= shift_cnt_next;
    end
  end

  // Address bytes: written per group or octet, or moved one place per
  // cycle during gap expansion, with a zero entering at the gap.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ipv6p_pkg::BYTE_COUNT; i++) begin
      if (rst || cmd.emit) begin
        addr_bytes[i] <= 8'd0;
      end else if (cmd.shift) begin
        if (5'(i) == gap_pos) begin
          addr_bytes[i] <= 8'd0;
        end else if (5'(i) > gap_pos) begin
          addr_bytes[i] <= addr_bytes[(i + ipv6p_pkg::BYTE_COUNT - 1) % ipv6p_pkg::BYTE_COUNT];
        end
      end else if (wr_a_en && wr_a_idx == 4'(i)) begin
        addr_bytes[i] <= wr_a_data;
      end else if (wr_b_en && wr_b_idx == 4'(i)) begin
        addr_bytes[i] <= wr_b_data;
      end
    end
  end

  // Result register, loaded when the controller emits.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_word.valid_res <= fin_ok;
      for (int i = 0; i < 8; i++) begin
        res_word.addr_high[63 - 8 * i -: 8] <= fin_ok ? addr_bytes[i] : 8'd0;
        res_word.addr_low[63 - 8 * i -: 8]  <= fin_ok ? addr_bytes[i + 8] : 8'd0;
      end
    end
  end

  assign status.shift_pending = (shift_cnt != 5'd0);
  assign status.shift_last    = (shift_cnt == 5'd1);

  `ASSERT_IMPLY(a_shift_only_ok, clk, rst, shift_cnt != 5'd0, fin_ok, "gap expansion on failed text")
  `ASSERT_IMPLY(a_shift_pending, clk, rst, cmd.shift, shift_cnt != 5'd0, "shift with nothing pending")
  `ASSERT_NEXT(a_emit_clears, clk, rst, cmd.emit, at_start && !failed && (write_pos == 5'd0), "parser not cleared after result")

endmodule

`default_nettype wire

// ===== rtl/ipv6p_ctrl.sv =====
// Controller of the IPv6 text parser: input handshake, end sequencing
// and the result valid flag. Uses ipv6p_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipv6p_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   char_valid,
  input  wire logic                   end_req,
  output logic                        char_ready,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  input  wire ipv6p_pkg::dp_status_t  status,
  output ipv6p_pkg::dp_cmd_t          cmd
);

  ipv6p_pkg::ctrl_state_t state, state_next;
  logic accept;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ipv6p_pkg::ST_RUN: begin
        if (accept && end_req) begin
          state_next = ipv6p_pkg::ST_SHIFT;
        end
      end
      ipv6p_pkg::ST_SHIFT: begin
        if (!status.shift_pending || status.shift_last) begin
          state_next = ipv6p_pkg::ST_EMIT;
        end
      end
      ipv6p_pkg::ST_EMIT: begin
        state_next = ipv6p_pkg::ST_RUN;
      end
      default: begin
        state_next = ipv6p_pkg::ST_RUN;
      end
    endcase
  end

  // Outputs. An end word waits while an earlier result is still held.
  always_comb begin
    char_ready    = 1'b0;
    cmd.step_char = 1'b0;
    cmd.finish    = 1'b0;
    cmd.shift     = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      ipv6p_pkg::ST_RUN: begin
        char_ready    = !end_req || !res_valid || res_ready;
        cmd.step_char = char_valid && char_ready && !end_req;
        cmd.finish    = char_valid && char_ready && end_req;
      end
      ipv6p_pkg::ST_SHIFT: begin
        cmd.shift = status.shift_pending;
      end
      ipv6p_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        char_ready = 1'b0;
      end
    endcase
  end

  assign accept = char_valid && char_ready;

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipv6p_pkg::ST_RUN;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_emit_slot_free, clk, rst, state == ipv6p_pkg::ST_EMIT, !res_valid, "result overwritten")
  `ASSERT_NEXT(a_end_to_shift, clk, rst, accept && end_req, state == ipv6p_pkg::ST_SHIFT, "end word not sequenced")
  `ASSERT_IMPLY(a_ready_in_run, clk, rst, char_ready, state == ipv6p_pkg::ST_RUN, "ready outside run state")

endmodule

`default_nettype wire

// ===== rtl/ipv6_text_address_parser_core.sv =====
// Top level of the IPv6 text address parser: controller plus datapath.
// Uses ipv6p_pkg, ipv6p_ctrl and ipv6p_dp.
//
//   channel | signals                          | word type
//   --------+----------------------------------+----------------------
//   char    | char_valid, char_ready, char_word | ipv6p_pkg::in_word_t
//   res     | res_valid, res_ready, res_word    | ipv6p_pkg::out_word_t
//
// Characters stream at one per cycle while the controller is in its run state.
// An end word holds the input while the controller passes through its shift
// state, where a gap is filled by single-byte shifts of the address register,
// and then its emit state.
// Reset is synchronous and needs no clearing pass; the block is ready at once.
// A character is accepted while a result waits; an end word waits until the
// result register is free.
`default_nettype none

module ipv6_text_address_parser_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  char_valid,
  output logic                       char_ready,
  input  wire ipv6p_pkg::in_word_t   char_word,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output ipv6p_pkg::out_word_t       res_word
);

  ipv6p_pkg::dp_cmd_t    cmd;
  ipv6p_pkg::dp_status_t status;

  // Sequencing of characters, end checks and result hand-off.
  ipv6p_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .end_req    (char_word.end_req),
    .char_ready (char_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Parse state, address bytes and result register.
  ipv6p_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ch       (char_word.ch),
    .cmd      (cmd),
    .status   (status),
    .res_word (res_word)
  );

endmodule

`default_nettype wire

// ===== test/tb_ipv6_text_address_parser_core.sv =====
// Self-checking testbench for ipv6_text_address_parser_core: streams address texts
// a character word at a time and checks every end-of-text result word against a
// predictor held in a small scoreboard class. Depends on ipv6p_pkg and the RTL only.
`default_nettype none

module tb_ipv6_text_address_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int TARGET_WORDS = 1850;
  localparam int MIN_TEXTS    = 40;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int REPORT_MAX   = 10;

  // Predicts the parse of each address text and holds the result words still due.
  class ipv6_text_scoreboard;
    logic [7:0]  addr_bytes [16];
    logic [4:0]  write_pos;
    logic [4:0]  gap_pos;
    logic        gap_seen;
    logic [15:0] group_value;
    logic [2:0]  group_digits;
    logic [8:0]  token_decimal;
    logic        token_not_octet;
    logic        dotted_mode;
    logic [2:0]  octet_count;
    logic [7:0]  octet_value;
    logic        octet_has_digit;
    logic        at_start;
    logic        need_second_colon;
    logic        colon_after_group;
    logic        failed;
    ipv6p_pkg::out_word_t expected_addrs [$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_group();
      group_value     = '0;
      group_digits    = '0;
      token_decimal   = '0;
      token_not_octet = 1'b0;
    endfunction

    function void clear_text();
      foreach (addr_bytes[i]) addr_bytes[i] = '0;
      write_pos         = '0;
      gap_pos           = '0;
      gap_seen          = 1'b0;
      clear_group();
      dotted_mode       = 1'b0;
      octet_count       = '0;
      octet_value       = '0;
      octet_has_digit   = 1'b0;
      at_start          = 1'b1;
      need_second_colon = 1'b0;
      colon_after_group = 1'b0;
      failed            = 1'b0;
    endfunction

    // Value of a hex digit in either case, or -1 for anything else.
    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    // One character of the trailing IPv4 quad.
    function void dotted_char(logic [7:0] c);
      int nw;
      if (c >= ipv6p_pkg::CHAR_0 && c <= ipv6p_pkg::CHAR_9) begin
        if (octet_has_digit && octet_value == 0) begin
          failed = 1'b1;
          return;
        end
        nw = int'(octet_value) * 10 + int'(c) - int'(ipv6p_pkg::CHAR_0);
        if (nw > 255) begin
          failed = 1'b1;
          return;
        end
        octet_value = nw[7:0];
        if (!octet_has_digit) begin
          if (octet_count >= 4) begin
            failed = 1'b1;
            return;
          end
          octet_count++;
          octet_has_digit = 1'b1;
        end
        addr_bytes[4'(write_pos + octet_count - 1)] = octet_value;
      end else if (c == ipv6p_pkg::CHAR_DOT && octet_has_digit) begin
        if (octet_count >= 4) begin
          failed = 1'b1;
          return;
        end
        octet_value     = '0;
        octet_has_digit = 1'b0;
      end else begin
        failed = 1'b1;
      end
    endfunction

    // Advances the parse by one ordinary character.
    function void eat_char(logic [7:0] c);
      int d;
      int nw;
      if (failed) return;
      if (at_start) begin
        at_start = 1'b0;
        if (c == ipv6p_pkg::CHAR_COLON) begin
          need_second_colon = 1'b1;
          return;
        end
      end
      if (need_second_colon) begin
        need_second_colon = 1'b0;
        if (c != ipv6p_pkg::CHAR_COLON) begin
          failed = 1'b1;
          return;
        end
      end
      if (dotted_mode) begin
        dotted_char(c);
        return;
      end
      d = digit_of(c);
      if (d >= 0) begin
        colon_after_group = 1'b0;
        if (group_digits >= 4) begin
          failed = 1'b1;
          return;
        end
        group_value = {group_value[11:0], 4'(d)};
        // Track whether the token could still be the first octet of a quad.
        if (d > 9) begin
          token_not_octet = 1'b1;
        end else if (group_digits > 0 && token_decimal == 0) begin
          token_not_octet = 1'b1;
        end else if (!token_not_octet) begin
          nw = int'(token_decimal) * 10 + d;
          if (nw > 255) token_not_octet = 1'b1;
          else token_decimal = nw[8:0];
        end
        group_digits++;
      end else if (c == ipv6p_pkg::CHAR_COLON) begin
        if (group_digits == 0) begin
          if (gap_seen) begin
            failed = 1'b1;
            return;
          end
          gap_seen          = 1'b1;
          gap_pos           = write_pos;
          colon_after_group = 1'b0;
          return;
        end
        if (write_pos > 14) begin
          failed = 1'b1;
          return;
        end
        addr_bytes[write_pos[3:0]]    = group_value[15:8];
        addr_bytes[4'(write_pos + 1)] = group_value[7:0];
        write_pos = write_pos + 5'd2;
        clear_group();
        colon_after_group = 1'b1;
      end else if (c == ipv6p_pkg::CHAR_DOT) begin
        colon_after_group = 1'b0;
        if (write_pos > 12 || group_digits == 0 || token_not_octet) begin
          failed = 1'b1;
          return;
        end
        addr_bytes[write_pos[3:0]] = token_decimal[7:0];
        dotted_mode     = 1'b1;
        octet_count     = 3'd1;
        octet_value     = '0;
        octet_has_digit = 1'b0;
        clear_group();
      end else begin
        failed = 1'b1;
      end
    endfunction

    // Closes the text: flushes the last group and expands the gap.
    function bit text_complete();
      logic [7:0] moved [16];
      int n;
      if (failed || need_second_colon) return 1'b0;
      if (dotted_mode) begin
        if (octet_count < 4) return 1'b0;
        write_pos = write_pos + 5'd4;
      end else begin
        if (colon_after_group) return 1'b0;
        if (group_digits != 0) begin
          if (write_pos > 14) return 1'b0;
          addr_bytes[write_pos[3:0]]    = group_value[15:8];
          addr_bytes[4'(write_pos + 1)] = group_value[7:0];
          write_pos = write_pos + 5'd2;
        end
      end
      if (gap_seen) begin
        if (write_pos >= 16 || gap_pos > write_pos) return 1'b0;
        n = int'(write_pos) - int'(gap_pos);
        moved = addr_bytes;
        for (int i = int'(gap_pos); i < 16; i++) addr_bytes[i] = '0;
        for (int i = 0; i < n; i++) addr_bytes[16 - n + i] = moved[(int'(gap_pos) + i) % 16];
        write_pos = 5'd16;
      end
      return write_pos == 16;
    endfunction

    // Notes an accepted input word; an end word queues the predicted result.
    function void note_word(ipv6p_pkg::in_word_t w);
      ipv6p_pkg::out_word_t r;
      if (!w.end_req) begin
        eat_char(w.ch);
        return;
      end
      r = '0;
      if (text_complete()) begin
        r.valid_res = 1'b1;
        for (int i = 0; i < 8; i++) begin
          r.addr_high = {r.addr_high[55:0], addr_bytes[i]};
          r.addr_low  = {r.addr_low[55:0], addr_bytes[i + 8]};
        end
      end
      expected_addrs.push_back(r);
      clear_text();
    endfunction

    function void note_fault(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    // Compares an accepted result word with the oldest prediction.
    function void check_result(ipv6p_pkg::out_word_t got);
      ipv6p_pkg::out_word_t want;
      if (expected_addrs.size() == 0) begin
        note_fault($sformatf("unexpected result word: valid=%0b high=%h low=%h",
                             got.valid_res, got.addr_high, got.addr_low));
        return;
      end
      want = expected_addrs.pop_front();
      if (got.valid_res !== want.valid_res || got.addr_high !== want.addr_high ||
          got.addr_low !== want.addr_low) begin
        note_fault($sformatf({"result mismatch: expected valid=%0b high=%h low=%h, ",
                              "got valid=%0b high=%h low=%h"},
                             want.valid_res, want.addr_high, want.addr_low,
                             got.valid_res, got.addr_high, got.addr_low));
      end
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 char_valid = 1'b0;
  ipv6p_pkg::in_word_t  char_word  = '0;
  logic                 res_ready  = 1'b0;
  logic                 char_ready;
  logic                 res_valid;
  ipv6p_pkg::out_word_t res_word;

  ipv6_text_scoreboard sb;
  logic [7:0]  addr_text [$];
  int          sent_words   = 0;
  int          texts_closed = 0;
  int          char_run     = 0;
  int          res_run      = 0;
  int unsigned cycles       = 0;

  ipv6_text_address_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[ipv6_text_address_parser_core] ERROR");
      $finish;
    end
  end

  // Idle cycles before the next word, with occasional runs of back-to-back words.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) run_left = $urandom_range(8, 48);
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return ipv6p_pkg::CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? ipv6p_pkg::CHAR_UA : ipv6p_pkg::CHAR_LA) + 8'(v - 10);
  endfunction

  function automatic void push_group();
    int n;
    n = ($urandom_range(0, 24) == 0) ? 5 : $urandom_range(1, 4);
    repeat (n) addr_text.push_back(hex_char($urandom_range(0, 15)));
  endfunction

  function automatic void push_decimal(int v);
    if (v >= 100) addr_text.push_back(ipv6p_pkg::CHAR_0 + 8'(v / 100));
    if (v >= 10) addr_text.push_back(ipv6p_pkg::CHAR_0 + 8'((v / 10) % 10));
    addr_text.push_back(ipv6p_pkg::CHAR_0 + 8'(v % 10));
  endfunction

  // Mostly legal octets, now and then a leading zero or a value over 255.
  function automatic void push_octet();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: begin
        addr_text.push_back(ipv6p_pkg::CHAR_0);
        addr_text.push_back(ipv6p_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
      end
      1: push_decimal($urandom_range(256, 999));
      2: push_decimal(255);
      3: push_decimal(0);
      default: push_decimal($urandom_range(0, 255));
    endcase
  endfunction

  // A mostly well-formed address, with or without a gap and a trailing quad.
  function automatic void build_address();
    bit dotted;
    int slots;
    int left_n;
    int right_n;
    dotted = ($urandom_range(0, 3) == 0);
    slots  = dotted ? 6 : 8;
    if ($urandom_range(0, 1)) begin
      // A gap; now and then it is left covering nothing.
      right_n = $urandom_range(0, 11) == 0 ? slots : $urandom_range(0, slots - 1);
      left_n  = $urandom_range(0, right_n);
      right_n = right_n - left_n;
      for (int i = 0; i < left_n; i++) begin
        push_group();
        addr_text.push_back(ipv6p_pkg::CHAR_COLON);
      end
      if (left_n == 0) addr_text.push_back(ipv6p_pkg::CHAR_COLON);
      addr_text.push_back(ipv6p_pkg::CHAR_COLON);
      for (int i = 0; i < right_n; i++) begin
        if (i > 0) addr_text.push_back(ipv6p_pkg::CHAR_COLON);
        push_group();
      end
      if (dotted && right_n > 0) addr_text.push_back(ipv6p_pkg::CHAR_COLON);
    end else begin
      for (int i = 0; i < slots; i++) begin
        if (i > 0) addr_text.push_back(ipv6p_pkg::CHAR_COLON);
        push_group();
      end
      if (dotted) addr_text.push_back(ipv6p_pkg::CHAR_COLON);
    end
    if (dotted) begin
      for (int i = 0; i < 4; i++) begin
        if (i > 0) addr_text.push_back(ipv6p_pkg::CHAR_DOT);
        push_octet();
      end
    end
  endfunction

  // Breaks a well-formed text in one place.
  function automatic void mutate_text();
    string pool;
    int p;
    pool = ":.0aF";
    p = (addr_text.size() == 0) ? 0 : $urandom_range(0, addr_text.size() - 1);
    case ($urandom_range(0, 7))
      0: if (addr_text.size() > 0) addr_text[p] = 8'($urandom_range(0, 255));
      1: if (addr_text.size() > 0) addr_text[p] = pool[$urandom_range(0, pool.len() - 1)];
      2: if (addr_text.size() > 0) addr_text.delete(p);
      3: addr_text.insert(p, ipv6p_pkg::CHAR_COLON);
      4: addr_text.push_back(ipv6p_pkg::CHAR_COLON);
      5: begin
        addr_text.push_back(ipv6p_pkg::CHAR_COLON);
        push_group();
      end
      6: addr_text.push_front(ipv6p_pkg::CHAR_COLON);
      default: addr_text.insert(p, ipv6p_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
    endcase
  endfunction

  // Short texts of likely characters and arbitrary bytes.
  function automatic void push_noise();
    string pool;
    pool = ":.09aAfFgG/@";
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 2) == 0) addr_text.push_back(8'($urandom_range(0, 255)));
      else addr_text.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    end
  endfunction

  // Offers one word; returns at the edge that accepts it, with valid still high.
  task automatic send_word(input ipv6p_pkg::in_word_t w);
    int idle;
    idle = draw_wait(char_run);
    if (idle > 0) begin
      char_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    do @(posedge clk); while (!char_ready);
    sb.note_word(w);
    sent_words++;
  endtask

  // Sends the text held in addr_text, then an end word with a junk character.
  task automatic send_text();
    ipv6p_pkg::in_word_t w;
    foreach (addr_text[i]) begin
      w.ch      = addr_text[i];
      w.end_req = 1'b0;
      send_word(w);
    end
    w.ch      = 8'($urandom_range(0, 255));
    w.end_req = 1'b1;
    send_word(w);
    texts_closed++;
  endtask

  task automatic send_string(input string s);
    addr_text = {};
    for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
    send_text();
  endtask

  // Result side: random stalls on ready, checking each accepted word.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait(res_run);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res_word);
    end
  end

  // Reset, directed texts, random texts, then drain and verdict.
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty text, a NUL, the top character code, the colon corner cases, a five-digit group and a gap before a quad.
    addr_text = {};
    send_text();
    addr_text = {8'h00};
    send_text();
    addr_text = {8'hff};
    send_text();
    send_string(":1");
    send_string("::");
    send_string("1:");
    send_string(":::");
    send_string("aF0f9");
    send_string("::1.2.3.4");

    while (sent_words < TARGET_WORDS || texts_closed < MIN_TEXTS) begin
      addr_text = {};
      if ($urandom_range(0, 99) < 78) begin
        build_address();
        if ($urandom_range(0, 99) < 35) mutate_text();
      end else begin
        push_noise();
      end
      send_text();
    end
    char_valid <= 1'b0;

    while (sb.expected_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_addrs.size() == 0) begin
      $display("[ipv6_text_address_parser_core] OK");
    end else begin
      $display("[ipv6_text_address_parser_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ipv6_text_address_parser_core.f =====
+incdir+rtl
rtl/ipv6p_pkg.sv
rtl/ipv6p_dp.sv
rtl/ipv6p_ctrl.sv
rtl/ipv6_text_address_parser_core.sv
test/tb_ipv6_text_address_parser_core.sv
